// File: design/wtp_pkg.sv
package wtp_pkg;

  localparam int ID_W       = 40;
  localparam int WINDOW_MAX = 8;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int SW_W       = 4;

  localparam logic [SW_W-1:0] WIN_SIZE_RESET = SW_W'(4);

  // Register map: word index taken from paddr[2].
  localparam logic REG_WIN_SIZE = 1'b0;

  typedef struct packed {
    logic [ID_W-1:0] keyword_id;
    logic            doc_last;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] low_id;
    logic [ID_W-1:0] high_id;
    logic            run_last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0] low_id;
    logic [ID_W-1:0] high_id;
  } pair_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             load;
    logic             step;
    logic             drop;
  } win_ctrl_t;

  // A window of zero behaves as one, anything above the maximum as the maximum.
  function automatic logic [CNT_W-1:0] eff_window(input logic [SW_W-1:0] sw);
    logic [CNT_W-1:0] w;
    if (sw == '0) begin
      w = CNT_W'(1);
    end else if (int'(sw) > WINDOW_MAX) begin
      w = CNT_W'(WINDOW_MAX);
    end else begin
      w = CNT_W'(sw);
    end
    return w;
  endfunction

endpackage

// File: design/wtp_window.sv
module wtp_window (
  input  logic                      clk,
  input  wtp_pkg::win_ctrl_t        ctrl,
  input  logic [wtp_pkg::ID_W-1:0]  wr_id,
  output logic [wtp_pkg::ID_W-1:0]  head_id,
  output logic [wtp_pkg::ID_W-1:0]  follower_id
);

  // Pending keywords, oldest at index 0.
  logic [wtp_pkg::ID_W-1:0] buf_r  [wtp_pkg::WINDOW_MAX];
  // Followers of the head entry; shifted toward index 0 once per follower examined.
  logic [wtp_pkg::ID_W-1:0] scan_r [wtp_pkg::WINDOW_MAX-1];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      buf_r[ctrl.wr_idx] <= wr_id;
    end else if (ctrl.drop) begin
      for (int i = 0; i < wtp_pkg::WINDOW_MAX - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end

    if (ctrl.load) begin
      for (int i = 0; i < wtp_pkg::WINDOW_MAX - 1; i++) begin
        scan_r[i] <= buf_r[i+1];
      end
    end else if (ctrl.step) begin
      for (int i = 0; i < wtp_pkg::WINDOW_MAX - 2; i++) begin
        scan_r[i] <= scan_r[i+1];
      end
    end
  end

  assign head_id     = buf_r[0];
  assign follower_id = scan_r[0];

endmodule

// File: design/wtp_pair_unit.sv
module wtp_pair_unit (
  input  logic [wtp_pkg::ID_W-1:0] a_id,
  input  logic [wtp_pkg::ID_W-1:0] b_id,
  output logic                     differ,
  output wtp_pkg::pair_t           pair
);

  logic a_lower;

  assign a_lower = (a_id < b_id);
  assign differ  = (a_id != b_id);

  always_comb begin
    if (a_lower) begin
      pair.low_id  = a_id;
      pair.high_id = b_id;
    end else begin
      pair.low_id  = b_id;
      pair.high_id = a_id;
    end
  end

endmodule

// File: design/window_term_pair_generator.sv
// Sequence: an item is taken while the sequencer idles; then every entry that is paired
// passes through a decide state, a pair step per follower and a drop state, and a closing
// decide state and a flush state that releases the last pair end the item.
// Throughput: one item at a time; in_ready is high only while the sequencer idles.
// At most one pair leaves per cycle; a stalled out_ready stalls the follower scan.
// Reset (rst_n low, synchronous) empties the window and sets the window size to 4.
module window_term_pair_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wtp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wtp_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PAIR,
    ST_DROP,
    ST_FLUSH
  } state_t;

  state_t                          state_r, state_nxt;
  logic [wtp_pkg::SW_W-1:0]        win_size_r, win_size_nxt;
  logic [wtp_pkg::IDX_W-1:0]       fill_r, fill_nxt;
  logic [wtp_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [wtp_pkg::IDX_W-1:0]       k_r, k_nxt;
  logic                            last_r, last_nxt;
  logic                            hold_v_r, hold_v_nxt;
  wtp_pkg::pair_t                  hold_pair_r, hold_pair_nxt;
  logic                            out_v_r, out_v_nxt;
  wtp_pkg::out_item_t              out_data_r, out_data_nxt;

  wtp_pkg::win_ctrl_t              wctl;
  logic [wtp_pkg::ID_W-1:0]        head_id;
  logic [wtp_pkg::ID_W-1:0]        follower_id;
  logic                            differ;
  wtp_pkg::pair_t                  pair;

  logic [wtp_pkg::CNT_W-1:0]       eff_w;
  logic [wtp_pkg::CNT_W-1:0]       wm1;
  logic [wtp_pkg::CNT_W-1:0]       followers;
  logic                            go_entry;
  logic                            out_free;
  logic                            cfg_wr;

  wtp_window u_window (
    .clk         (clk),
    .ctrl        (wctl),
    .wr_id       (in_data.keyword_id),
    .head_id     (head_id),
    .follower_id (follower_id)
  );

  wtp_pair_unit u_pair (
    .a_id   (head_id),
    .b_id   (follower_id),
    .differ (differ),
    .pair   (pair)
  );

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == wtp_pkg::REG_WIN_SIZE) ?
                     32'(win_size_r) : 32'd0;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_v_r || out_ready;

  assign eff_w = wtp_pkg::eff_window(win_size_r);
  assign wm1   = eff_w - wtp_pkg::CNT_W'(1);

  always_comb begin
    state_nxt       = state_r;
    win_size_nxt    = win_size_r;
    fill_nxt        = fill_r;
    cnt_nxt         = cnt_r;
    k_nxt           = k_r;
    last_nxt        = last_r;
    hold_v_nxt      = hold_v_r;
    hold_pair_nxt   = hold_pair_r;
    out_v_nxt       = out_v_r && !out_ready;
    out_data_nxt    = out_data_r;
    wctl            = '0;
    go_entry        = 1'b0;
    followers       = '0;

    if (cfg_wr && paddr[2] == wtp_pkg::REG_WIN_SIZE) begin
      win_size_nxt = pwdata[wtp_pkg::SW_W-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          wctl.wr_en  = 1'b1;
          wctl.wr_idx = fill_r;
          cnt_nxt     = wtp_pkg::CNT_W'(fill_r) + wtp_pkg::CNT_W'(1);
          last_nxt    = in_data.doc_last;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // Mid-document an entry is paired only once its window is full;
        // the last item of a document drains every pending entry.
        go_entry = last_r ? (cnt_r != '0) : (cnt_r >= eff_w);
        if (go_entry) begin
          if (last_r && (cnt_r - wtp_pkg::CNT_W'(1)) < wm1) begin
            followers = cnt_r - wtp_pkg::CNT_W'(1);
          end else begin
            followers = wm1;
          end
          wctl.load = 1'b1;
          k_nxt     = followers[wtp_pkg::IDX_W-1:0];
          state_nxt = (followers == '0) ? ST_DROP : ST_PAIR;
        end else begin
          fill_nxt  = cnt_r[wtp_pkg::IDX_W-1:0];
          state_nxt = ST_FLUSH;
        end
      end
      ST_PAIR: begin
        // A new pair pushes the held one out, so the held pair may wait
        // for the output register before the scan moves on.
        if (!(differ && hold_v_r && !out_free)) begin
          if (differ) begin
            if (hold_v_r) begin
              out_v_nxt    = 1'b1;
              out_data_nxt = '{low_id: hold_pair_r.low_id,
                               high_id: hold_pair_r.high_id,
                               run_last: 1'b0};
            end
            hold_pair_nxt = pair;
            hold_v_nxt    = 1'b1;
          end
          wctl.step = 1'b1;
          k_nxt     = k_r - wtp_pkg::IDX_W'(1);
          if (k_r == wtp_pkg::IDX_W'(1)) begin
            state_nxt = ST_DROP;
          end
        end
      end
      ST_DROP: begin
        wctl.drop = 1'b1;
        cnt_nxt   = cnt_r - wtp_pkg::CNT_W'(1);
        state_nxt = ST_DECIDE;
      end
      ST_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_data_nxt = '{low_id: hold_pair_r.low_id,
                           high_id: hold_pair_r.high_id,
                           run_last: 1'b1};
          hold_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      win_size_r    <= wtp_pkg::WIN_SIZE_RESET;
      fill_r        <= '0;
      cnt_r         <= '0;
      k_r           <= '0;
      last_r        <= 1'b0;
      hold_v_r      <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      win_size_r    <= win_size_nxt;
      fill_r        <= fill_nxt;
      cnt_r         <= cnt_nxt;
      k_r           <= k_nxt;
      last_r        <= last_nxt;
      hold_v_r      <= hold_v_nxt;
      out_v_r       <= out_v_nxt;
    end
    hold_pair_r <= hold_pair_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_idle_no_held_pair: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !hold_v_r)
    else $error("held pair left over while idle");

  a_pair_has_follower: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAIR) |-> (k_r != '0))
    else $error("follower scan entered with no followers");

  a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && hold_v_r && out_free) |=> (out_v_r && out_data_r.run_last))
    else $error("final pair of an item not marked");

  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(hold_v_r))
    else $error("result issued without a held pair");

endmodule
